### hdl/dwws_pkg.sv
// Shared types and constants for the weighted window sum block.
// Field widths, register indexes, state encodings and the scan tap struct.
// No dependencies.
package dwws_pkg;

   localparam int INDEX_BITS     = 16;
   localparam int IN_VALUE_BITS  = 16;
   localparam int TOTAL_BITS     = 26;
   localparam int DIM_BITS       = 17;
   localparam int RADIUS_BITS    = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CELL_BITS      = 2 * DIM_BITS;

   // Edge cells add half their value.
   localparam int HALF_SHIFT = 1;

   localparam logic [DIM_BITS-1:0]    RESET_DIM    = 17'd256;
   localparam logic [RADIUS_BITS-1:0] RESET_RADIUS = 4'd7;
   localparam logic [TOTAL_BITS-1:0]  TOTAL_MAX    = '1;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GRID_COLS = 2'd0,
      CSR_GRID_ROWS = 2'd1,
      CSR_RADIUS    = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_BUSY,
      TOP_DELIVER
   } top_state_type;

   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_SETUP,
      SCAN_RUN
   } scan_state_type;

   typedef struct packed {
      logic valid;
      logic half;
      logic last;
   } tap_type;

endpackage

### hdl/dwws_if.sv
// Valid/ready channel interfaces: request, response and register write.
// Depends on dwws_pkg for the field widths.
interface dwws_req_if import dwws_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [INDEX_BITS-1:0]    cell_index;
   logic [IN_VALUE_BITS-1:0] cell_value;

   modport source (output valid, output func, output cell_index, output cell_value,
                   input ready);
   modport sink   (input valid, input func, input cell_index, input cell_value,
                   output ready);
endinterface

interface dwws_rsp_if import dwws_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TOTAL_BITS-1:0] disk_total;

   modport source (output valid, output disk_total, input ready);
   modport sink   (input valid, input disk_total, output ready);
endinterface

interface dwws_csr_if import dwws_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [DIM_BITS-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/dwws_grid_mem.sv
// Grid cell store: one write port, one read port with registered read data.
// No dependencies.
module dwws_grid_mem #(
   parameter int ADDR_BITS  = 16,
   parameter int VALUE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_BITS-1:0]  wr_addr,
   input  logic [VALUE_BITS-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_BITS-1:0]  rd_addr,
   output logic [VALUE_BITS-1:0] rd_data
);

   logic [VALUE_BITS-1:0] mem [2**ADDR_BITS];
   logic [VALUE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dwws_scan.sv
// Window scan sequencer: walks the square of offsets around a centre and
// issues one read per cell inside the disk and the grid. Uses dwws_pkg.
module dwws_scan import dwws_pkg::*; #(
   parameter int ADDR_BITS  = 16,
   parameter int MAX_RADIUS = 15
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [INDEX_BITS-1:0]  centre,
   input  logic [DIM_BITS-1:0]    grid_cols,
   input  logic [DIM_BITS-1:0]    grid_rows,
   input  logic [RADIUS_BITS-1:0] radius,
   output logic                   rd_en,
   output logic [ADDR_BITS-1:0]   rd_addr,
   output tap_type                tap
);

   localparam int RB     = $clog2(MAX_RADIUS + 1);
   localparam int OB     = RB + 1;
   localparam int DB     = 2 * RB + 2;
   localparam int LB_MIN = DIM_BITS + RB + 2;
   localparam int LB     = (LB_MIN > ADDR_BITS + 1) ? LB_MIN : ADDR_BITS + 1;

   scan_state_type state_ff, state_in;

   logic [INDEX_BITS-1:0] centre_ff, centre_in;
   logic [RB-1:0]         r_ff, r_in;
   logic [CELL_BITS-1:0]  cells_ff, cells_in;
   logic [LB-1:0]         lin_ff, lin_in;
   logic [LB-1:0]         row_step_ff, row_step_in;
   logic [OB-1:0]         i_ff, i_in;
   logic [OB-1:0]         j_ff, j_in;
   logic [DB-1:0]         outer_ff, outer_in;
   logic [DB-1:0]         inner_ff, inner_in;

   logic [OB-1:0]          r_pos, neg_r, r_plus1, i_neg, j_neg;
   logic [RB-1:0]          r_minus1, i_mag, j_mag;
   logic [DIM_BITS+RB-1:0] r_times_cols;
   logic [DB-1:0]          dist_sq;
   logic                   in_disk, in_grid, row_end, last;

   assign r_pos        = {1'b0, r_ff};
   assign neg_r        = ~r_pos + OB'(1);
   assign r_plus1      = r_pos + OB'(1);
   assign r_minus1     = (r_ff == '0) ? RB'(1) : r_ff - RB'(1);
   assign r_times_cols = (DIM_BITS+RB)'(r_ff) * (DIM_BITS+RB)'(grid_cols);

   assign i_neg   = ~i_ff + OB'(1);
   assign j_neg   = ~j_ff + OB'(1);
   assign i_mag   = i_ff[OB-1] ? i_neg[RB-1:0] : i_ff[RB-1:0];
   assign j_mag   = j_ff[OB-1] ? j_neg[RB-1:0] : j_ff[RB-1:0];
   assign dist_sq = DB'(i_mag) * DB'(i_mag) + DB'(j_mag) * DB'(j_mag);

   assign in_disk = dist_sq <= outer_ff;
   assign in_grid = !lin_ff[LB-1] && (CELL_BITS'(lin_ff[LB-2:0]) < cells_ff);
   assign row_end = i_ff == r_pos;
   assign last    = row_end && (j_ff == r_pos);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SCAN_IDLE: begin
            if (start) begin
               state_in = SCAN_SETUP;
            end
         end
         SCAN_SETUP: begin
            state_in = SCAN_RUN;
         end
         SCAN_RUN: begin
            if (last) begin
               state_in = SCAN_IDLE;
            end
         end
         default: begin
            state_in = SCAN_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      rd_en     = 1'b0;
      tap.valid = 1'b0;
      tap.half  = dist_sq > inner_ff;
      tap.last  = 1'b0;
      case (state_ff)
         SCAN_RUN: begin
            rd_en     = in_disk && in_grid;
            tap.valid = in_disk && in_grid;
            tap.last  = last;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   assign rd_addr = lin_ff[ADDR_BITS-1:0];

   // Datapath next values
   always_comb begin
      centre_in   = centre_ff;
      r_in        = r_ff;
      cells_in    = cells_ff;
      lin_in      = lin_ff;
      row_step_in = row_step_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      outer_in    = outer_ff;
      inner_in    = inner_ff;
      case (state_ff)
         SCAN_IDLE: begin
            // Latch centre, clamp radius, take the grid size.
            centre_in = centre;
            cells_in  = CELL_BITS'(grid_cols) * CELL_BITS'(grid_rows);
            if (32'(radius) > MAX_RADIUS) begin
               r_in = RB'(MAX_RADIUS);
            end else begin
               r_in = RB'(radius);
            end
         end
         SCAN_SETUP: begin
            // First neighbor sits at centre - r*cols - r.
            lin_in      = LB'(centre_ff) - LB'(r_times_cols) - LB'(r_ff);
            row_step_in = LB'(grid_cols) - LB'({r_ff, 1'b0});
            i_in        = neg_r;
            j_in        = neg_r;
            outer_in    = DB'(r_plus1) * DB'(r_plus1);
            inner_in    = DB'(r_minus1) * DB'(r_minus1);
         end
         SCAN_RUN: begin
            if (row_end) begin
               i_in   = neg_r;
               j_in   = j_ff + OB'(1);
               lin_in = lin_ff + row_step_ff;
            end else begin
               i_in   = i_ff + OB'(1);
               lin_in = lin_ff + LB'(1);
            end
         end
         default: begin
            lin_in = lin_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      centre_ff   <= centre_in;
      r_ff        <= r_in;
      cells_ff    <= cells_in;
      lin_ff      <= lin_in;
      row_step_ff <= row_step_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      outer_ff    <= outer_in;
      inner_ff    <= inner_in;
   end

endmodule

### hdl/dwws_accum.sv
// Weighted accumulator: adds read data, halved for edge cells, and
// saturates the total at the end of a scan. Uses dwws_pkg.
module dwws_accum import dwws_pkg::*; #(
   parameter int VALUE_BITS = 16,
   parameter int MAX_RADIUS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  tap_type               tap,
   input  logic [VALUE_BITS-1:0] rd_data,
   output logic                  done,
   output logic [TOTAL_BITS-1:0] total
);

   localparam int RB = $clog2(MAX_RADIUS + 1);
   localparam int AB = VALUE_BITS + 2 * RB + 2;

   tap_type               tap_ff;
   logic                  done_ff;
   logic [AB-1:0]         acc_ff, acc_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic [AB-1:0]         addend, sum;

   // Tap is registered to line up with the registered read data.
   always_comb begin
      addend = '0;
      if (tap_ff.valid) begin
         if (tap_ff.half) begin
            addend = AB'(rd_data >> HALF_SHIFT);
         end else begin
            addend = AB'(rd_data);
         end
      end
   end

   assign sum    = acc_ff + addend;
   assign acc_in = clear ? '0 : sum;

   always_comb begin
      total_in = total_ff;
      if (tap_ff.last) begin
         if (64'(sum) > 64'(TOTAL_MAX)) begin
            total_in = TOTAL_MAX;
         end else begin
            total_in = TOTAL_BITS'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         tap_ff  <= tap;
         done_ff <= tap_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      total_ff <= total_in;
   end

   assign done  = done_ff;
   assign total = total_ff;

endmodule

### hdl/disk_weighted_window_sum.sv
// Weighted disk sum over a stored grid.
// Write item: stored at the accept edge; the next item is taken the cycle after.
// Query item: the scan steps through every offset of the square around the centre, with one memory
// read per offset inside the disk and the grid, r being the clamped radius; the next item is taken
// once the result has entered the output register, later when the previous result still waits there.
// Reset: synchronous, active high; cols = rows = 256, radius = 7. Grid memory is not cleared.
module disk_weighted_window_sum import dwws_pkg::*; #(
   parameter int ADDR_BITS  = 16,
   parameter int VALUE_BITS = 16,
   parameter int MAX_RADIUS = 15
) (
   input  logic        clock,
   input  logic        reset,
   dwws_req_if.sink    req_ch,
   dwws_rsp_if.source  rsp_ch,
   dwws_csr_if.sink    csr_ch
);

   top_state_type state_ff, state_in;

   // Configuration registers
   logic [DIM_BITS-1:0]    grid_cols_ff, grid_cols_in;
   logic [DIM_BITS-1:0]    grid_rows_ff, grid_rows_in;
   logic [RADIUS_BITS-1:0] radius_ff, radius_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_BITS-1:0] rsp_total_ff, rsp_total_in;

   logic                  req_accept, wr_en, start, out_free, load;
   logic                  rd_en, done;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [VALUE_BITS-1:0] rd_data;
   logic [TOTAL_BITS-1:0] total;
   tap_type               tap;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign wr_en      = req_accept && (req_ch.func == FUNC_WRITE);
   assign start      = req_accept && (req_ch.func == FUNC_QUERY);
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // Register writes are always taken; unknown indexes are dropped.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      radius_in    = radius_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_GRID_COLS: grid_cols_in = csr_ch.data;
            CSR_GRID_ROWS: grid_rows_in = csr_ch.data;
            CSR_RADIUS:    radius_in    = csr_ch.data[RADIUS_BITS-1:0];
            default:       radius_in    = radius_ff;
         endcase
      end
   end

   // Next state: hold in BUSY for the scan, park in DELIVER while the
   // output register is still full.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         TOP_IDLE: begin
            if (start) begin
               state_in = TOP_BUSY;
            end
         end
         TOP_BUSY: begin
            if (done) begin
               state_in = out_free ? TOP_IDLE : TOP_DELIVER;
            end
         end
         TOP_DELIVER: begin
            if (out_free) begin
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase
   end

   // Outputs of the control FSM
   always_comb begin
      req_ch.ready = 1'b0;
      load         = 1'b0;
      case (state_ff)
         TOP_IDLE: begin
            req_ch.ready = 1'b1;
         end
         TOP_BUSY: begin
            load = done && out_free;
         end
         TOP_DELIVER: begin
            load = out_free;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   // The accumulator holds its total until the next scan, so DELIVER can
   // still take it from there.
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ch.ready);
   assign rsp_total_in = load ? total : rsp_total_ff;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.disk_total = rsp_total_ff;

   dwws_grid_mem #(
      .ADDR_BITS  (ADDR_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_grid_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_BITS'(req_ch.cell_index)),
      .wr_data (VALUE_BITS'(req_ch.cell_value)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dwws_scan #(
      .ADDR_BITS  (ADDR_BITS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .centre    (req_ch.cell_index),
      .grid_cols (grid_cols_ff),
      .grid_rows (grid_rows_ff),
      .radius    (radius_ff),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .tap       (tap)
   );

   dwws_accum #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .clear   (start),
      .tap     (tap),
      .rd_data (rd_data),
      .done    (done),
      .total   (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         rsp_valid_ff <= 1'b0;
         grid_cols_ff <= RESET_DIM;
         grid_rows_ff <= RESET_DIM;
         radius_ff    <= RESET_RADIUS;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
         radius_ff    <= radius_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_total_ff <= rsp_total_in;
   end

endmodule

### bench/disk_weighted_window_sum_test.sv
// Testbench for disk_weighted_window_sum: random and directed grid writes and disk queries.
// A scoreboard class predicts every disk_total; bursty request and stalling response sides.
// Depends on dwws_pkg, the dwws_*_if interfaces and the disk_weighted_window_sum RTL.
module disk_weighted_window_sum_test;
   import dwws_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RESET_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 16;    // margin for the last write to retire
   localparam int TAIL_CYCLES    = 1000;  // longer than one query at the largest radius
   localparam int HOLD_CYCLES    = 3000;  // long response hold-off, several queries deep
   localparam int REPORT_LIMIT   = 10;
   localparam int STORE_DEPTH    = 1 << INDEX_BITS;
   localparam int RUN_LIMIT_NS   = 50_000_000;
   localparam int PHASES         = 14;
   localparam int HOLD_PHASE     = 0;

   // Grid settings swept by the run, extremes included: single column or row, dimensions
   // of 65536, grids larger than the store, zero columns or rows, radius 0 and 15.
   int phase_cols [PHASES] = '{256, 16, 1, 65536, 65536, 300, 7, 3, 1, 0, 40, 12, 33, 65536};
   int phase_rows [PHASES] = '{256, 16, 65536, 1, 65536, 300, 9, 5, 1, 40, 0, 10, 6, 65536};
   int phase_rad  [PHASES] = '{7, 3, 5, 4, 2, 1, 15, 0, 2, 3, 6, 15, 6, 15};
   int phase_ops  [PHASES] = '{60, 60, 30, 30, 30, 30, 30, 30, 20, 20, 20, 30, 40, 20};

   // Scoreboard: holds its own copy of the grid and registers, predicts each disk_total
   // when a query item is accepted and matches results against the oldest prediction.
   class disk_total_book;
      bit [IN_VALUE_BITS-1:0]  cell_mem   [STORE_DEPTH];
      bit                      cell_known [STORE_DEPTH];
      logic [DIM_BITS-1:0]     cols;
      logic [DIM_BITS-1:0]     rows;
      logic [RADIUS_BITS-1:0]  radius;
      logic [TOTAL_BITS-1:0]   totals_due [$];
      logic [INDEX_BITS-1:0]   absent [$];
      int                      failures;

      function new();
         cols     = RESET_DIM;
         rows     = RESET_DIM;
         radius   = RESET_RADIUS;
         failures = 0;
      endfunction

      function void set_reg(csr_index_type which, logic [DIM_BITS-1:0] data);
         case (which)
            CSR_GRID_COLS: cols = data;
            CSR_GRID_ROWS: rows = data;
            CSR_RADIUS:    radius = data[RADIUS_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Weighted disk sum around centre; also collect cells read before ever written.
      function logic [TOTAL_BITS-1:0] scan_window(logic [INDEX_BITS-1:0] centre);
         longint cells, span, c, rw, outer, inner, d, lin, acc;
         logic [INDEX_BITS-1:0]    addr;
         logic [IN_VALUE_BITS-1:0] v;
         absent.delete();
         cells = longint'(cols) * longint'(rows);
         if (cells == 0) return '0;
         span  = longint'(radius);
         c     = longint'(centre) % longint'(cols);
         rw    = longint'(centre) / longint'(cols);
         outer = (span + 1) * (span + 1);
         inner = (span - 1) * (span - 1);
         acc   = 0;
         for (longint i = -span; i <= span; i++) begin
            for (longint j = -span; j <= span; j++) begin
               d = i * i + j * j;
               if (d > outer) continue;
               // linear addressing: neighbours may wrap across rows
               lin = (rw + j) * longint'(cols) + c + i;
               if (lin < 0 || lin >= cells) continue;
               addr = lin[INDEX_BITS-1:0];
               if (!cell_known[addr]) absent.insert(absent.size(), addr);
               v = cell_mem[addr];
               if (d > inner) v = v >> 1;
               acc += longint'(v);
            end
         end
         if (acc > longint'(TOTAL_MAX)) acc = longint'(TOTAL_MAX);
         return acc[TOTAL_BITS-1:0];
      endfunction

      function void take_item(func_type f, logic [INDEX_BITS-1:0] idx,
                              logic [IN_VALUE_BITS-1:0] val);
         if (f == FUNC_WRITE) begin
            cell_mem[idx]   = val;
            cell_known[idx] = 1'b1;
         end else begin
            totals_due.insert(totals_due.size(), scan_window(idx));
         end
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
      endfunction

      function void match_total(logic [TOTAL_BITS-1:0] got);
         logic [TOTAL_BITS-1:0] want;
         if (totals_due.size() == 0) begin
            note_failure($sformatf("disk_total %0d with no query waiting", got));
            return;
         end
         want = totals_due.pop_front();
         if (got !== want)
            note_failure($sformatf("disk_total expected %0d actual %0d", want, got));
      endfunction

      function int pending();
         return totals_due.size();
      endfunction
   endclass

   typedef enum int {
      SINK_OPEN,
      SINK_COIN,
      SINK_SPARSE,
      SINK_RHYTHM
   } sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dwws_req_if req ();
   dwws_rsp_if rsp ();
   dwws_csr_if csr ();

   disk_total_book book = new();

   bit  hold_go   = 1'b0;
   int  burst_left = 0;

   disk_weighted_window_sum uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stop a hung run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   // Response side: stall on a changing pattern; on request, hold off for a long
   // counted stretch so the block fills and stalls its input.
   initial begin
      sink_mode_type mode;
      int            mode_left;
      int            hold_left;
      bit            hold_taken;
      logic [7:0]    rhythm;
      mode       = SINK_OPEN;
      mode_left  = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rhythm     = 8'b1011_0010;
      rsp.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = sink_mode_type'($urandom_range(SINK_OPEN, SINK_RHYTHM));
               mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            rhythm = {rhythm[6:0], rhythm[7]};
            case (mode)
               SINK_OPEN:   rsp.ready <= 1'b1;
               SINK_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
               SINK_SPARSE: rsp.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp.ready <= rhythm[0];
            endcase
         end
      end
   end

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1)
         book.match_total(rsp.disk_total);
   end

   // Values: mostly random, sometimes the extremes.
   function automatic logic [IN_VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return IN_VALUE_BITS'($urandom);
      endcase
   endfunction

   // Centres: anywhere on small grids; on larger ones keep to small clusters at both
   // ends, so filled cells get reused.
   function automatic logic [INDEX_BITS-1:0] pick_centre();
      longint cells;
      int     roll;
      cells = longint'(book.cols) * longint'(book.rows);
      if (cells > STORE_DEPTH) cells = STORE_DEPTH;
      roll = $urandom_range(0, 99);
      if (cells == 0) return INDEX_BITS'($urandom);
      if (cells <= 256) begin
         if (roll < 10) return INDEX_BITS'($urandom);
         return INDEX_BITS'($urandom_range(0, int'(cells) - 1));
      end
      if (roll < 55) return INDEX_BITS'($urandom_range(0, 15));
      return INDEX_BITS'(cells - 1 - $urandom_range(0, 15));
   endfunction

   // Offer one item in bursts with random gaps; wait for the handshake and book it.
   task automatic send_item(func_type f, logic [INDEX_BITS-1:0] idx,
                            logic [IN_VALUE_BITS-1:0] val);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            3, 4, 5, 6, 7: gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 40);
         endcase
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req.valid      <= 1'b1;
      req.func       <= f;
      req.cell_index <= idx;
      req.cell_value <= val;
      do @(posedge clock); while (req.ready !== 1'b1);
      book.take_item(f, idx, val);
   endtask

   // Write every cell the query would read that was never written, then send the query.
   task automatic run_query(logic [INDEX_BITS-1:0] centre);
      logic [INDEX_BITS-1:0] missing [$];
      void'(book.scan_window(centre));
      missing = book.absent;
      foreach (missing[k]) send_item(FUNC_WRITE, missing[k], pick_value());
      send_item(FUNC_QUERY, centre, pick_value());
   endtask

   task automatic write_reg(csr_index_type which, logic [DIM_BITS-1:0] data);
      csr.valid <= 1'b1;
      csr.index <= which;
      csr.data  <= data;
      do @(posedge clock); while (csr.ready !== 1'b1);
      book.set_reg(which, data);
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      longint cells;
      req.valid      = 1'b0;
      req.func       = FUNC_WRITE;
      req.cell_index = '0;
      req.cell_value = '0;
      csr.valid      = 1'b0;
      csr.index      = CSR_GRID_COLS;
      csr.data       = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, under the reset settings: value extremes, alternating bit patterns,
      // an odd value on the rim of the disk around cell 0 so its half truncates,
      // corner centres whose neighbours fall below zero or past the last cell, and
      // centres at both ends of a row so neighbours wrap into the adjacent row.
      send_item(FUNC_WRITE, 16'h0000, 16'hFFFF);
      send_item(FUNC_WRITE, 16'hFFFF, 16'hFFFF);
      send_item(FUNC_WRITE, 16'h0002, 16'hAAAA);
      send_item(FUNC_WRITE, 16'h0003, 16'h5555);
      send_item(FUNC_WRITE, 16'h0007, 16'h0001);
      run_query(16'h0000);
      run_query(16'hFFFF);
      run_query(16'h00FF);
      run_query(16'h0100);
      run_query(16'h0003);
      send_item(FUNC_WRITE, 16'h0000, 16'h0000);
      run_query(16'h0000);

      for (int p = 0; p < PHASES; p++) begin
         // Pause the sender until every result is in, let the block settle, reprogram.
         req.valid <= 1'b0;
         while (book.pending() > 0) @(posedge clock);
         repeat (SETTLE_CYCLES) @(posedge clock);
         write_reg(CSR_GRID_COLS, DIM_BITS'(phase_cols[p]));
         write_reg(CSR_GRID_ROWS, DIM_BITS'(phase_rows[p]));
         write_reg(CSR_RADIUS, DIM_BITS'(phase_rad[p]));

         // Corners of this grid; zero-size grids get an arbitrary centre.
         cells = longint'(book.cols) * longint'(book.rows);
         if (cells > STORE_DEPTH) cells = STORE_DEPTH;
         run_query('0);
         run_query(cells == 0 ? INDEX_BITS'($urandom) : INDEX_BITS'(cells - 1));

         if (p == HOLD_PHASE) hold_go = 1'b1;

         for (int n = 0; n < phase_ops[p]; n++) begin
            if ($urandom_range(0, 99) < 35)
               send_item(FUNC_WRITE,
                         $urandom_range(0, 1) ? INDEX_BITS'($urandom) : pick_centre(),
                         pick_value());
            else
               run_query(pick_centre());
         end
      end

      // Drain, then watch a while for stray results.
      req.valid <= 1'b0;
      while (book.pending() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.failures == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### disk_weighted_window_sum.f
hdl/dwws_pkg.sv
hdl/dwws_if.sv
hdl/dwws_grid_mem.sv
hdl/dwws_scan.sv
hdl/dwws_accum.sv
hdl/disk_weighted_window_sum.sv
bench/disk_weighted_window_sum_test.sv
